[design/rgbm_enc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_enc_pkg
// Constants shared by the RGBM pixel encoder: default fixed-point format,
// scale factors for range 6, and the rounding mode codes.
// ----------------------------------------------------------------------------
package rgbm_enc_pkg;

  // Default component format, unsigned Q8.20
  localparam int FRACTION_BITS_DEF = 20;
  localparam int INTEGER_BITS_DEF  = 8;

  // a8 = max * 255 / 6 = (max * 85) >> (FRACTION_BITS + 1)
  localparam int RANGE_SCALE   = 85;
  localparam int RANGE_SCALE_W = 7;

  // colour ratio c * 85 / (2*a8+1) scaled by 255 gives c * 21675 / D
  localparam int COLOUR_SCALE   = 21675;
  localparam int COLOUR_SCALE_W = 15;

  // floor on the largest component, in LSB
  localparam int MIN_COMPONENT = 2;

  // result bytes
  localparam int BYTE_W   = 8;
  localparam int BYTE_MAX = 255;

  // round_mode register codes
  localparam logic ROUND_TRUNC   = 1'b0;
  localparam logic ROUND_HALF_UP = 1'b1;

endpackage

[design/rgbm_hdr_pixel_encode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_hdr_pixel_encode
// Pipelined RGBM (range 6) encoder for one HDR pixel per beat.
//
//   channel   | dir | handshake                     | payload
//   ----------+-----+-------------------------------+-------------------------
//   s_axis    | in  | s_axis_tvalid / s_axis_tready | red_in, green_in, blue_in
//   m_axis    | out | m_axis_tvalid / m_axis_tready | alpha, red, green, blue
//   cfg       | in  | cfg_we (no wait)              | round_mode
//
// One pixel enters per cycle while s_axis_tready is high. Its stages are max
// search, four constant multipliers, numerator add with saturation compare,
// then one stage per quotient bit of an 8-stage restoring divider.
// Each stage holds its beat while the next one is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated under back-pressure.
// Synchronous reset clears the stage valid bits and round_mode only.
// ----------------------------------------------------------------------------
module rgbm_hdr_pixel_encode #(
  parameter int FRACTION_BITS = rgbm_enc_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = rgbm_enc_pkg::INTEGER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  // round_mode register
  input  logic cfg_we,
  input  logic cfg_wdata,

  // input pixel stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // bits from LSB: red_in, green_in, blue_in, zero padding to whole bytes
  input  logic [((3*(INTEGER_BITS+FRACTION_BITS)+7)/8)*8-1:0] s_axis_tdata,

  // encoded pixel stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bits from LSB: alpha_byte, red_byte, green_byte, blue_byte
  output logic [31:0] m_axis_tdata
);

  import rgbm_enc_pkg::*;

  localparam int CW    = INTEGER_BITS + FRACTION_BITS;  // component width
  localparam int AW    = INTEGER_BITS + 6;              // a8 width (unclamped)
  localparam int DW    = AW + 1;                        // divisor 2*a8+1
  localparam int PW    = CW + COLOUR_SCALE_W;           // c * 21675
  localparam int NW    = INTEGER_BITS + 16;             // numerator >> FRACTION_BITS
  localparam int QB    = BYTE_W;                        // quotient bits
  localparam int NSTG  = 3 + QB;                        // pipeline depth

  // stage index: 0 max, 1 multiply, 2 numerator, 3 + j divider stage j (j = 0 .. QB-1)
  logic [NSTG-1:0] stage_valid;
  logic [NSTG-1:0] stage_en;

  logic round_mode;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      round_mode <= ROUND_TRUNC;
    end else if (cfg_we) begin
      round_mode <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or its beat moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    stage_en[NSTG-1] = !stage_valid[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign s_axis_tready = stage_en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, largest component floored at the minimum
  // ---------------------------------------------------------------------------
  logic [2:0][CW-1:0] comp_in;
  logic [CW-1:0]      max_rg;
  logic [CW-1:0]      max_rgb;
  logic [CW-1:0]      max_floor;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp_in[k] = s_axis_tdata[k*CW +: CW];
    end
    max_rg    = (comp_in[1] > comp_in[0]) ? comp_in[1] : comp_in[0];
    max_rgb   = (comp_in[2] > max_rg) ? comp_in[2] : max_rg;
    max_floor = (max_rgb < CW'(MIN_COMPONENT)) ? CW'(MIN_COMPONENT) : max_rgb;
  end

  logic [2:0][CW-1:0] s1_comp;
  logic [CW-1:0]      s1_max;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_comp <= comp_in;
      s1_max  <= max_floor;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: a8 from the maximum, colour numerators c * 21675
  // ---------------------------------------------------------------------------
  logic [CW+RANGE_SCALE_W-1:0] max_scaled;
  logic [2:0][PW-1:0]          colour_prod;

  always_comb begin
    max_scaled = {{RANGE_SCALE_W{1'b0}}, s1_max} * (CW+RANGE_SCALE_W)'(RANGE_SCALE);
    for (int k = 0; k < 3; k++) begin
      colour_prod[k] = {{COLOUR_SCALE_W{1'b0}}, s1_comp[k]} * PW'(COLOUR_SCALE);
    end
  end

  logic [AW-1:0]      s2_a8;
  logic [2:0][PW-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_a8   <= max_scaled[CW+RANGE_SCALE_W-1 -: AW];
      s2_prod <= colour_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rounding term, drop the fraction, saturation test, alpha byte
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0][NW-1:0]     rem;
    logic [2:0][QB-1:0]     quo;
    logic [2:0]             sat;
    logic [DW-1:0]          dvs;
    logic [BYTE_W-1:0]      alpha;
  } div_stage_t;

  logic [DW-1:0]        divisor;
  logic [PW:0]          round_term;
  logic [2:0][PW:0]     numer_sum;
  logic [NW-1:0]        sat_bound;
  logic [BYTE_W-1:0]    alpha_byte;
  div_stage_t           div_in;

  always_comb begin
    divisor    = {s2_a8, 1'b1};
    // half a divisor, so the truncating divide rounds half up
    round_term = (round_mode == ROUND_HALF_UP) ?
                 ({{(PW+1-DW){1'b0}}, divisor} << (FRACTION_BITS - 1)) : '0;
    sat_bound  = NW'({divisor, {QB{1'b0}}});

    if (s2_a8 >= AW'(BYTE_MAX)) begin
      alpha_byte = BYTE_W'(BYTE_MAX);
    end else if (round_mode == ROUND_HALF_UP) begin
      alpha_byte = s2_a8[BYTE_W-1:0] + BYTE_W'(1);
    end else begin
      alpha_byte = s2_a8[BYTE_W-1:0];
    end

    div_in.dvs   = divisor;
    div_in.alpha = alpha_byte;
    for (int k = 0; k < 3; k++) begin
      numer_sum[k]  = {1'b0, s2_prod[k]} + round_term;
      div_in.rem[k] = numer_sum[k][PW -: NW];
      // quotient of 256 or more clips to 255
      div_in.sat[k] = div_in.rem[k] >= sat_bound;
      div_in.quo[k] = '0;
    end
  end

  div_stage_t div_q [QB+1];

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      div_q[0] <= div_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int BIT = QB - 1 - j;

    logic [NW-1:0] trial;
    div_stage_t    div_next;

    always_comb begin
      trial    = NW'(div_q[j].dvs) << BIT;
      div_next = div_q[j];
      for (int k = 0; k < 3; k++) begin
        if (div_q[j].rem[k] >= trial) begin
          div_next.rem[k]      = div_q[j].rem[k] - trial;
          div_next.quo[k][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[3+j]) begin
        div_q[j+1] <= div_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: last divider stage is the output register
  // ---------------------------------------------------------------------------
  logic [2:0][BYTE_W-1:0] colour_byte;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      colour_byte[k] = div_q[QB].sat[k] ? BYTE_W'(BYTE_MAX) : div_q[QB].quo[k];
    end
  end

  assign m_axis_tvalid = stage_valid[NSTG-1];
  assign m_axis_tdata  = {colour_byte[2], colour_byte[1], colour_byte[0],
                          div_q[QB].alpha};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input back-pressure only when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (stage_valid == {NSTG{1'b1}}) && !m_axis_tready)
    else $error("input stalled while the pipeline has a bubble");

  // A finished, unsaturated quotient leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    stage_valid[NSTG-1] |->
      (div_q[QB].sat[0] || (div_q[QB].rem[0] < NW'(div_q[QB].dvs))) &&
      (div_q[QB].sat[1] || (div_q[QB].rem[1] < NW'(div_q[QB].dvs))) &&
      (div_q[QB].sat[2] || (div_q[QB].rem[2] < NW'(div_q[QB].dvs))))
    else $error("divider remainder not below divisor");

  // Reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (stage_valid == '0))
    else $error("stage valid set after reset");

endmodule

[verif/rgbm_hdr_pixel_encode_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbm_hdr_pixel_encode_tb
// Self-checking bench for the RGBM (range 6) pixel encoder. Pixels stream in
// on s_axis and encoded RGBM words stream out on m_axis. Each accepted pixel
// is encoded by an integer model kept in a small class, and every output beat
// is compared field by field with the oldest pending pixel. The run covers
// directed corner pixels, then random phases that alternate round_mode and
// vary source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module rgbm_hdr_pixel_encode_tb;
  import rgbm_enc_pkg::*;

  localparam int FB         = FRACTION_BITS_DEF;
  localparam int COMP_W     = INTEGER_BITS_DEF + FRACTION_BITS_DEF;
  localparam int TDATA_W    = ((3 * COMP_W + 7) / 8) * 8;
  localparam int PIPE_DEPTH = 11;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASES     = 8;
  localparam int PHASE_PIX  = 155;

  // Q8.20 landmarks: 1.0, and 6.0 where the multiplier reaches 255
  localparam logic [COMP_W-1:0] ONE      = COMP_W'(1) << FB;
  localparam logic [COMP_W-1:0] SIX      = COMP_W'(6) << FB;
  localparam logic [COMP_W-1:0] FULL     = '1;
  // largest component that still gives a zero multiplier
  localparam logic [COMP_W-1:0] A8_ZERO  = 24672;
  // smallest component that gives a multiplier of 254
  localparam logic [COMP_W-1:0] A8_254   = 6266784;

  typedef struct {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgbm_pixel_t;

  // Encodes each accepted pixel and holds the words still owed by the block.
  class rgbm_encode_tracker;
    rgbm_pixel_t expected_pixels[$];
    logic        mode;
    int          mismatches;

    function new();
      mode       = ROUND_TRUNC;
      mismatches = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function logic [7:0] colour_byte(logic [COMP_W-1:0] c, logic [63:0] denom);
      logic [63:0] q;
      if (mode == ROUND_HALF_UP) begin
        q = (64'(c) * (2 * COLOUR_SCALE) + denom) / (denom * 2);
      end else begin
        q = (64'(c) * COLOUR_SCALE) / denom;
      end
      return (q > BYTE_MAX) ? 8'(BYTE_MAX) : q[7:0];
    endfunction

    function void note_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                             logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] peak;
      logic [63:0]       a8;
      logic [63:0]       denom;
      rgbm_pixel_t       px;
      peak = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      // floor the peak so the divisor never collapses on black pixels
      if (peak < MIN_COMPONENT) peak = COMP_W'(MIN_COMPONENT);
      a8 = (64'(peak) * RANGE_SCALE) >> (FB + 1);
      if (a8 >= BYTE_MAX) begin
        px.alpha = 8'(BYTE_MAX);
      end else begin
        px.alpha = (mode == ROUND_HALF_UP) ? 8'(a8 + 1) : 8'(a8);
      end
      // colour bytes use the unclamped multiplier
      denom    = (a8 * 2 + 1) << FB;
      px.red   = colour_byte(r, denom);
      px.green = colour_byte(g, denom);
      px.blue  = colour_byte(b, denom);
      expected_pixels.push_back(px);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_encoded(logic [31:0] word);
      rgbm_pixel_t px;
      if (expected_pixels.size() == 0) begin
        $error("output beat 0x%08h with no pixel pending", word);
        mismatches++;
        return;
      end
      px = expected_pixels.pop_front();
      compare_field("alpha_byte", px.alpha, word[7:0]);
      compare_field("red_byte",   px.red,   word[15:8]);
      compare_field("green_byte", px.green, word[23:16]);
      compare_field("blue_byte",  px.blue,  word[31:24]);
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic               cfg_wdata     = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // bits from LSB: red_in, green_in, blue_in, zero padding
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // bits from LSB: alpha_byte, red_byte, green_byte, blue_byte
  logic [31:0]        m_axis_tdata;

  int                 idle_pct  = 0;
  int                 stall_pct = 0;
  int                 cycles    = 0;
  rgbm_encode_tracker tracker   = new();

  rgbm_hdr_pixel_encode dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("rgbm_hdr_pixel_encode verification failed");
      $finish;
    end
  end

  // Sink: stall at the phase's rate; zero means always ready.
  always @(posedge clk) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Check every output beat against the oldest pending pixel.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tracker.check_encoded(m_axis_tdata);
    end
  end

  // Present one pixel, with random idle cycles ahead of it, and hold it until
  // the block takes it. Valid stays high afterwards so back-to-back pixels
  // need no bubble.
  task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                            logic [COMP_W-1:0] b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({b, g, r});
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_pixel(r, g, b);
  endtask

  // Drop valid and hold off until every pending pixel has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Change round_mode only with the pipeline empty.
  task automatic write_mode(logic m);
    drain();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_mode(m);
  endtask

  task automatic send_random();
    logic [COMP_W-1:0] r, g, b, v;
    case ($urandom_range(4))
      0: begin
        // full range, every bit toggles
        r = COMP_W'($urandom);
        g = COMP_W'($urandom);
        b = COMP_W'($urandom);
      end
      1: begin
        // inside range 6, the normal working area
        r = COMP_W'($urandom_range(SIX));
        g = COMP_W'($urandom_range(SIX));
        b = COMP_W'($urandom_range(SIX));
      end
      2: begin
        // near black, multiplier stays tiny and colours saturate
        r = COMP_W'($urandom_range(2 * A8_ZERO));
        g = COMP_W'($urandom_range(2 * A8_ZERO));
        b = COMP_W'($urandom_range(2 * A8_ZERO));
      end
      3: begin
        // near grey
        v = COMP_W'($urandom_range(7 * ONE));
        r = v;
        g = v >> $urandom_range(3);
        b = v - (v >> $urandom_range(1, 8));
      end
      default: begin
        // one bright channel over dim ones
        v = COMP_W'($urandom);
        r = COMP_W'($urandom_range(ONE));
        g = COMP_W'($urandom_range(ONE));
        b = COMP_W'($urandom_range(ONE));
        case ($urandom_range(2))
          0:       r = v;
          1:       g = v;
          default: b = v;
        endcase
      end
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(ROUND_TRUNC);

    // Corner pixels: black, tiny, full scale, the multiplier steps at 0, 254
    // and 255, saturated colour ratios, alternating bit patterns.
    send_pixel(0, 0, 0);
    send_pixel(1, 0, 0);
    send_pixel(2, 2, 2);
    send_pixel(3, 1, 0);
    send_pixel(FULL, FULL, FULL);
    send_pixel(FULL, 0, 0);
    send_pixel(0, FULL, 0);
    send_pixel(0, 0, FULL);
    send_pixel(SIX, SIX, SIX);
    send_pixel(SIX - 1, 1, SIX - 1);
    send_pixel(SIX + 1, SIX >> 1, 0);
    send_pixel(A8_254, 100000, A8_254 - 1);
    send_pixel(A8_ZERO, 24000, A8_ZERO >> 1);
    send_pixel(A8_ZERO + 1, 0, 1);
    send_pixel(ONE, ONE >> 1, ONE >> 2);
    send_pixel(28'hAAAAAAA, 28'h5555555, 28'hFFFFFFF);

    for (int p = 0; p < PHASES; p++) begin
      // toggle the rounding mode and rotate through the gap patterns
      write_mode((p % 2 == 0) ? ROUND_HALF_UP : ROUND_TRUNC);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      for (int i = 0; i < PHASE_PIX; i++) begin
        // mid-phase, let the pipeline run completely empty
        if (i == PHASE_PIX / 2) drain();
        send_random();
      end
    end

    drain();
    stall_pct = 0;
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("rgbm_hdr_pixel_encode verification clean");
    end else begin
      $display("rgbm_hdr_pixel_encode verification failed");
    end
    $finish;
  end

endmodule
